@@ src/ssed_pkg.sv @@
// ----------------------------------------------------------------------------
// ssed_pkg
// Shared types and character codes for the script string escaper.
// ----------------------------------------------------------------------------
package ssed_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 12;
    localparam int unsigned COUNT_W = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1017;

    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              vld;
        logic              done;
    } res_t;

    // results caused by one input transaction
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } pair_t;

endpackage

@@ src/ssed_escape.sv @@
// ----------------------------------------------------------------------------
// ssed_escape
// Escape decision and string state: limit register, held lead byte and count.
// ----------------------------------------------------------------------------
module ssed_escape (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [ssed_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic                            in_accept,
    input  logic [ssed_pkg::BYTE_W-1:0]     in_byte,
    input  logic                            in_last,
    output ssed_pkg::pair_t                 pair
);

    logic [ssed_pkg::LIMIT_W-1:0] limit_reg;
    logic                         lead_pending_reg, lead_pending_next;
    logic [ssed_pkg::BYTE_W-1:0]  held_lead_reg, held_lead_next;
    logic [ssed_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         reached_reg, reached_next;

    logic                         lr;
    logic [1:0]                   n;
    logic [ssed_pkg::BYTE_W-1:0]  d0, d1;
    logic [ssed_pkg::COUNT_W-1:0] limit_ext;
    logic                         is_esc;

    assign limit_ext = {1'b0, limit_reg};
    assign is_esc    = (in_byte == ssed_pkg::CH_APOS) || (in_byte == ssed_pkg::CH_SLASH) ||
                       (in_byte == ssed_pkg::CH_BSLASH);

    always_comb begin
        lr                = reached_reg || (count_reg >= limit_ext);
        lead_pending_next = lead_pending_reg;
        held_lead_next    = held_lead_reg;
        count_next        = count_reg;
        reached_next      = 1'b1;
        n                 = 2'd0;
        d0                = '0;
        d1                = '0;
        if (!lr) begin
            if (lead_pending_reg) begin
                lead_pending_next = 1'b0;
                d0 = (in_byte < ssed_pkg::CH_SPACE) ? ssed_pkg::CH_SPACE : held_lead_reg;
                d1 = in_byte;
                n  = 2'd2;
                count_next = count_reg + 13'd1;
            end else if (is_esc) begin
                d0 = ssed_pkg::CH_BSLASH;
                d1 = in_byte;
                n  = 2'd2;
                count_next = count_reg + 13'd2;
            end else if (in_byte == ssed_pkg::CH_LF) begin
                d0 = ssed_pkg::CH_BSLASH;
                d1 = ssed_pkg::CH_N;
                n  = 2'd2;
                count_next = count_reg + 13'd2;
            end else if (in_byte == ssed_pkg::CH_CR) begin
                n = 2'd0;
            end else if (in_byte[ssed_pkg::BYTE_W-1]) begin
                lead_pending_next = 1'b1;
                held_lead_next    = in_byte;
                count_next        = count_reg + 13'd1;
            end else begin
                d0 = in_byte;
                n  = 2'd1;
                count_next = count_reg + 13'd1;
            end
            reached_next = (count_next >= limit_ext);
        end

        pair.r0 = '{data: d0, vld: 1'b1, done: 1'b0};
        pair.r1 = '{data: d1, vld: 1'b1, done: 1'b0};
        pair.n  = n;

        if (in_last) begin
            case (n)
                2'd0: begin
                    pair.n  = 2'd1;
                    pair.r0 = '{data: '0, vld: 1'b0, done: 1'b1};
                end
                2'd1: pair.r0.done = 1'b1;
                default: pair.r1.done = 1'b1;
            endcase
            lead_pending_next = 1'b0;
            held_lead_next    = '0;
            count_next        = '0;
            reached_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg        <= ssed_pkg::LIMIT_RESET;
            lead_pending_reg <= 1'b0;
            held_lead_reg    <= '0;
            count_reg        <= '0;
            reached_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            if (in_accept) begin
                lead_pending_reg <= lead_pending_next;
                held_lead_reg    <= held_lead_next;
                count_reg        <= count_next;
                reached_reg      <= reached_next;
            end
        end
    end

endmodule

@@ src/ssed_outbuf.sv @@
// ----------------------------------------------------------------------------
// ssed_outbuf
// Two-slot result register, drained one transaction per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module ssed_outbuf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  ssed_pkg::pair_t             pair,
    output logic                        can_load,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ssed_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    logic [1:0]     cnt_reg, cnt_next;
    ssed_pkg::res_t slot0_reg, slot1_reg;
    ssed_pkg::res_t head;
    logic           pop;

    assign head     = (cnt_reg == 2'd2) ? slot0_reg : slot1_reg;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head.data;
    assign m_tuser  = head.vld;
    assign m_tlast  = head.done;
    assign pop      = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = pair.n;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pair.n == 2'd2) begin
                slot0_reg <= pair.r0;
                slot1_reg <= pair.r1;
            end else begin
                slot1_reg <= pair.r0;
            end
        end
    end

endmodule

@@ src/script_string_escaper_dbcs_unit.sv @@
// ----------------------------------------------------------------------------
// script_string_escaper_dbcs_unit
// Escapes a byte stream for a quoted script string, double-byte aware.
// ----------------------------------------------------------------------------
// An input byte that yields at most one output transaction is taken every
// cycle while m_tready is high; a byte that yields two (an escape pair or a
// lead and trail pair) holds the input until the first of the two is taken.
// The hold is set by the two-slot result register, which presents one result
// per cycle while m_tready is high. The first result is presented in the
// cycle after its input byte is accepted. A string's last result carries
// m_tlast; m_tuser low marks a bare end marker with no data byte.
module script_string_escaper_dbcs_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [ssed_pkg::LIMIT_W-1:0]  cfg_wdata,  // output_limit
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ssed_pkg::BYTE_W-1:0]   s_tdata,    // in_byte
    input  logic                          s_tlast,    // end_of_string
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ssed_pkg::BYTE_W-1:0]   m_tdata,    // out_byte
    output logic                          m_tuser,    // byte_valid
    output logic                          m_tlast     // string_done
);

    ssed_pkg::pair_t pair;
    logic            can_load;
    logic            in_accept;

    assign s_tready  = can_load;
    assign in_accept = s_tvalid && can_load;

    ssed_escape u_escape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .pair      (pair)
    );

    ssed_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_accept),
        .pair     (pair),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/ssed_checker.sv @@
// ----------------------------------------------------------------------------
// ssed_checker
// Port-level checks for the script string escaper.
// ----------------------------------------------------------------------------
module ssed_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ssed_pkg::BYTE_W-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);

    // bare end marker only closes a string
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("end marker without tlast");

    // empty result register always takes input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with nothing pending");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind script_string_escaper_dbcs_unit ssed_checker u_ssed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-byte aware script string escaper. Byte
// strings go in over the slave stream and are predicted in the scoreboard. The
// scoreboard checks every result transaction in order. A directed section
// covers each escape, the lead and trail handling and the limit corners.
// Random phases follow with varied limits and sender and receiver stalls.
// ----------------------------------------------------------------------------

class escape_scoreboard;
    logic [ssed_pkg::LIMIT_W-1:0] out_limit;
    logic                         lead_held;
    logic [ssed_pkg::BYTE_W-1:0]  lead_byte;
    logic [ssed_pkg::COUNT_W-1:0] out_count;
    logic                         limit_hit;
    ssed_pkg::res_t               expected_q[$];
    int                           errors;

    function new();
        out_limit = ssed_pkg::LIMIT_RESET;
        lead_held = 1'b0;
        lead_byte = '0;
        out_count = '0;
        limit_hit = 1'b0;
        errors    = 0;
    endfunction

    function void set_limit(logic [ssed_pkg::LIMIT_W-1:0] v);
        out_limit = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void add_byte(logic [ssed_pkg::BYTE_W-1:0] b);
        ssed_pkg::res_t r;
        r.data = b;
        r.vld  = 1'b1;
        r.done = 1'b0;
        expected_q.push_back(r);
    endfunction

    // predict the results of one accepted input transaction
    function void note_byte(logic [ssed_pkg::BYTE_W-1:0] b, logic last);
        int             base;
        ssed_pkg::res_t r;
        base = expected_q.size();
        if (!limit_hit && out_count >= {1'b0, out_limit})
            limit_hit = 1'b1;
        if (!limit_hit) begin
            if (lead_held) begin
                lead_held = 1'b0;
                add_byte((b < 8'd32) ? ssed_pkg::CH_SPACE : lead_byte);
                add_byte(b);
                out_count = out_count + 13'd1;
            end else if (b == ssed_pkg::CH_APOS || b == ssed_pkg::CH_SLASH ||
                         b == ssed_pkg::CH_BSLASH) begin
                add_byte(ssed_pkg::CH_BSLASH);
                add_byte(b);
                out_count = out_count + 13'd2;
            end else if (b == ssed_pkg::CH_LF) begin
                add_byte(ssed_pkg::CH_BSLASH);
                add_byte(ssed_pkg::CH_N);
                out_count = out_count + 13'd2;
            end else if (b == ssed_pkg::CH_CR) begin
                // dropped
            end else if (b >= 8'd128) begin
                lead_held = 1'b1;
                lead_byte = b;
                out_count = out_count + 13'd1;
            end else begin
                add_byte(b);
                out_count = out_count + 13'd1;
            end
            if (out_count >= {1'b0, out_limit})
                limit_hit = 1'b1;
        end
        if (last) begin
            if (expected_q.size() == base) begin
                r.data = '0;
                r.vld  = 1'b0;
                r.done = 1'b1;
                expected_q.push_back(r);
            end else begin
                expected_q[expected_q.size()-1].done = 1'b1;
            end
            lead_held = 1'b0;
            lead_byte = '0;
            out_count = '0;
            limit_hit = 1'b0;
        end
    endfunction

    function void check_result(logic [ssed_pkg::BYTE_W-1:0] data, logic vld, logic done);
        ssed_pkg::res_t e;
        if (expected_q.size() == 0) begin
            $display("%0t unexpected result: expected none, got data %h vld %b done %b",
                     $time, data, vld, done);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (e.data !== data || e.vld !== vld || e.done !== done) begin
            $display("%0t mismatch: expected data %h vld %b done %b, got data %h vld %b done %b",
                     $time, e.data, e.vld, e.done, data, vld, done);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 104;
    localparam int NUM_PHASES   = 8;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_wen   = 1'b0;
    logic [ssed_pkg::LIMIT_W-1:0] cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [ssed_pkg::BYTE_W-1:0]  s_tdata   = '0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [ssed_pkg::BYTE_W-1:0]  m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    escape_scoreboard sb = new();
    int               idle_mode = 0;
    int               cycle_cnt = 0;

    script_string_escaper_dbcs_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check and random stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        case (idle_mode)
            2: begin
                m_tready <= ($urandom_range(0, 99) >= 46);
            end
            3: begin
                m_tready <= ($urandom_range(0, 99) >= 8);
            end
            default: begin
                m_tready <= 1'b1;
            end
        endcase
    end

    function automatic int send_gap_pct();
        if (idle_mode == 1)
            return 46;
        if (idle_mode == 3)
            return 8;
        return 0;
    endfunction

    task automatic send_byte(logic [ssed_pkg::BYTE_W-1:0] b, logic last);
        while ($urandom_range(0, 99) < send_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_byte(b, last);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    task automatic write_limit(logic [ssed_pkg::LIMIT_W-1:0] v);
        wait_drain();
        repeat (4) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.set_limit(v);
    endtask

    function automatic logic [ssed_pkg::BYTE_W-1:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 4))
                0: return ssed_pkg::CH_APOS;
                1: return ssed_pkg::CH_SLASH;
                2: return ssed_pkg::CH_BSLASH;
                3: return ssed_pkg::CH_LF;
                default: return ssed_pkg::CH_CR;
            endcase
        end
        if (r < 40)
            return 8'($urandom_range(128, 255));
        if (r < 52)
            return 8'($urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [ssed_pkg::LIMIT_W-1:0] phase_limit(int ph);
        case (ph)
            0: return 12'd4095;
            1: return 12'($urandom_range(2, 40));
            2: return 12'd2;
            3: return 12'($urandom_range(2, 4095));
            4: return 12'($urandom_range(41, 200));
            5: return 12'd3;
            6: return 12'($urandom_range(2, 40));
            default: return ssed_pkg::LIMIT_RESET;
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every escape, lead and trail cases, pending lead at end
        send_byte(ssed_pkg::CH_APOS, 1'b0);
        send_byte(ssed_pkg::CH_SLASH, 1'b0);
        send_byte(ssed_pkg::CH_BSLASH, 1'b0);
        send_byte(ssed_pkg::CH_LF, 1'b0);
        send_byte(ssed_pkg::CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(ssed_pkg::CH_APOS, 1'b0);
        send_byte(8'h81, 1'b1);
        // bare end markers
        send_byte(ssed_pkg::CH_CR, 1'b1);
        send_byte(8'hFF, 1'b1);
        // escape pair crossing the limit, then an ignored byte
        write_limit(12'd2);
        send_byte(8'h61, 1'b0);
        send_byte(ssed_pkg::CH_LF, 1'b0);
        send_byte(8'h63, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_limit(phase_limit(ph));
            idle_mode = ph % 4;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(20, 60);
                else
                    len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_byte(rand_byte(), i == len - 1);
                    sent++;
                    if (sent == PHASE_ITEMS / 2)
                        wait_drain();
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
